// File: rtl/tesig_pkg.sv
`timescale 1ns / 1ps

package tesig_pkg;

    // field widths
    localparam int P_W     = 16;
    localparam int T_W     = 24;
    localparam int M_W     = 16;
    localparam int COEF_W  = 20;
    localparam int S_W     = 16;
    localparam int SIG_W   = 20;
    localparam int BIN_W   = 4;

    // serial multiplier: wide operand by narrow operand, one bit a cycle
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = 64;

    // serial divider: one quotient bit a cycle
    localparam int DIVD_W  = 56;
    localparam int DIVS_W  = 33;

    // square root: two radicand bits a cycle
    localparam int RAD_W   = 42;
    localparam int ROOT_W  = RAD_W / 2;

    localparam int DPP_W   = 37;
    localparam int SUM_W   = RAD_W;
    localparam int TBL_DEPTH = 16;

    localparam logic [SIG_W-1:0] MAX_SIGMA = '1;
    localparam int NBINS   = 10;
    localparam int NBOUNDS = 11;
    localparam logic [DIVS_W-1:0] GEV_MEV = 33'd1000;

    // opcodes carried in tuser of an input word
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // register indexes on the configuration port
    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_B = 3'd1;
    localparam logic [2:0] REG_C = 3'd2;
    localparam logic [2:0] REG_D = 3'd3;
    localparam logic [2:0] REG_S = 3'd4;

    // momentum bin boundaries in MeV/c
    function automatic logic [P_W-1:0] bound_mev(input int idx);
        logic [P_W-1:0] b;
        unique case (idx)
            0:       b = 16'd300;
            1:       b = 16'd500;
            2:       b = 16'd600;
            3:       b = 16'd700;
            4:       b = 16'd800;
            5:       b = 16'd900;
            6:       b = 16'd1000;
            7:       b = 16'd1200;
            8:       b = 16'd1500;
            9:       b = 16'd2000;
            default: b = 16'd3000;
        endcase
        return b;
    endfunction

    // count of leading boundaries exceeded, capped, minus one
    function automatic logic [BIN_W-1:0] find_bin(input logic [P_W-1:0] p);
        logic [BIN_W:0] cnt;
        cnt = '0;
        for (int i = 0; i < NBOUNDS; i++) begin
            if (i < NBINS && p > bound_mev(i)) begin
                cnt = cnt + 1'b1;
            end
        end
        return (cnt == '0) ? '0 : BIN_W'(cnt - 1'b1);
    endfunction

endpackage

// File: rtl/tof_expected_time_sigma_core.sv
`timescale 1ns / 1ps

// Expected time-of-flight resolution for one track. A word with tuser = 1 computes
// sqrt(st^2 + ms^2 + s^2 + t0^2) from momentum, mass and flight time and returns one
// word with the 20-bit sigma (clipped, with tuser set on clipping) and the momentum
// bin; a word with tuser = 0 writes the start-time resolution table entry picked by
// the low 4 momentum bits and returns nothing. A compute runs on one shared shift-add
// multiplier (ten products), one shared restoring divider (four quotients) and a square
// root, all run one after another, and ends early when the momentum spread alone clips.
// One item is worked on at a time; a new item is taken while the last result still
// waits at the output.
module tof_expected_time_sigma_core
    import tesig_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // momentum[15:0], flight_time[39:16], particle_mass[55:40], load_value[71:56]
    input  logic [71:0] s_axis_tdata,
    // opcode[0]
    input  logic        s_axis_tuser,
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // expected_sigma[19:0], momentum_bin[23:20]
    output logic [23:0] m_axis_tdata,
    // saturated[0]
    output logic        m_axis_tuser
);

    typedef enum logic [4:0] {
        S_IDLE, S_BP, S_BP_DIV, S_CM, S_CM_DIV, S_MM, S_PP, S_TM, S_TM_DIV,
        S_DR, S_SQ_ST, S_MS_DIV, S_SQ_MS, S_SQ_S, S_SQ_T0, S_SQRT, S_OUT
    } t_state;

    t_state r_state;

    logic [COEF_W-1:0] r_a, r_b, r_c, r_d;
    logic [S_W-1:0]    r_s;
    logic [S_W-1:0]    r_table [TBL_DEPTH];

    logic [P_W-1:0]    r_p;
    logic [M_W-1:0]    r_m;
    logic [T_W-1:0]    r_t;
    logic [BIN_W-1:0]  r_bin;
    logic [DPP_W-1:0]  r_dpp;
    logic [31:0]       r_m2;
    logic [DIVS_W-1:0] r_den;
    logic [SUM_W-1:0]  r_sum;
    logic [SIG_W-1:0]  r_root;
    logic              r_sat;

    logic               r_mul_go, r_div_go, r_sqrt_go;
    logic [MUL_A_W-1:0] r_mul_a;
    logic [MUL_B_W-1:0] r_mul_b;
    logic [DIVD_W-1:0]  r_div_n;
    logic [DIVS_W-1:0]  r_div_d;

    logic               r_ov;
    logic [SIG_W-1:0]   r_o_sig;
    logic [BIN_W-1:0]   r_o_bin;
    logic               r_o_sat;

    logic               mul_done, div_done, sqrt_done;
    logic [PROD_W-1:0]  mul_prod;
    logic [DIVD_W-1:0]  div_quot;
    logic [ROOT_W-1:0]  sqrt_root;

    logic [P_W-1:0]     in_p;
    logic [M_W-1:0]     in_m;
    logic [PROD_W-21:0] st_full;

    tesig_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_mul_go),
        .i_a    (r_mul_a),
        .i_b    (r_mul_b),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    tesig_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_go),
        .i_dividend(r_div_n),
        .i_divisor (r_div_d),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    tesig_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_sqrt_go),
        .i_rad  (r_sum),
        .o_done (sqrt_done),
        .o_root (sqrt_root)
    );

    // zero momentum and mass count as one
    assign in_p    = (s_axis_tdata[15:0] == '0) ? 16'd1 : s_axis_tdata[15:0];
    assign in_m    = (s_axis_tdata[55:40] == '0) ? 16'd1 : s_axis_tdata[55:40];
    assign st_full = mul_prod[PROD_W-1:20];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_o_bin, r_o_sig};
    assign m_axis_tuser  = r_o_sat;

    // sequencer, register file, table and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_a       <= 20'd8389;
            r_b       <= 20'd8389;
            r_c       <= 20'd2097;
            r_d       <= 20'd40000;
            r_s       <= '0;
            r_mul_go  <= 1'b0;
            r_div_go  <= 1'b0;
            r_sqrt_go <= 1'b0;
            r_ov      <= 1'b0;
            for (int i = 0; i < TBL_DEPTH; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            r_mul_go  <= 1'b0;
            r_div_go  <= 1'b0;
            r_sqrt_go <= 1'b0;

            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_A:   r_a <= i_cfg_data;
                    REG_B:   r_b <= i_cfg_data;
                    REG_C:   r_c <= i_cfg_data;
                    REG_D:   r_d <= i_cfg_data;
                    REG_S:   r_s <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // output word taken, unless a new one replaces it this cycle
            if (r_ov && m_axis_tready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == OP_LOAD) begin
                            r_table[s_axis_tdata[3:0]] <= s_axis_tdata[71:56];
                        end else begin
                            r_p      <= in_p;
                            r_m      <= in_m;
                            r_t      <= s_axis_tdata[39:16];
                            r_bin    <= find_bin(in_p);
                            r_sat    <= 1'b0;
                            r_mul_a  <= MUL_A_W'(r_b);
                            r_mul_b  <= MUL_B_W'(in_p);
                            r_mul_go <= 1'b1;
                            r_state  <= S_BP;
                        end
                    end
                end
                S_BP: begin
                    if (mul_done) begin
                        r_div_n  <= DIVD_W'(mul_prod);
                        r_div_d  <= GEV_MEV;
                        r_div_go <= 1'b1;
                        r_state  <= S_BP_DIV;
                    end
                end
                S_BP_DIV: begin
                    if (div_done) begin
                        r_dpp    <= DPP_W'(r_a) + DPP_W'(div_quot);
                        r_mul_a  <= MUL_A_W'(r_c);
                        r_mul_b  <= MUL_B_W'(r_m);
                        r_mul_go <= 1'b1;
                        r_state  <= S_CM;
                    end
                end
                S_CM: begin
                    if (mul_done) begin
                        r_div_n  <= DIVD_W'(mul_prod);
                        r_div_d  <= DIVS_W'(r_p);
                        r_div_go <= 1'b1;
                        r_state  <= S_CM_DIV;
                    end
                end
                S_CM_DIV: begin
                    if (div_done) begin
                        r_dpp    <= r_dpp + DPP_W'(div_quot);
                        r_mul_a  <= MUL_A_W'(r_m);
                        r_mul_b  <= MUL_B_W'(r_m);
                        r_mul_go <= 1'b1;
                        r_state  <= S_MM;
                    end
                end
                S_MM: begin
                    if (mul_done) begin
                        r_m2     <= mul_prod[31:0];
                        r_mul_a  <= MUL_A_W'(r_p);
                        r_mul_b  <= MUL_B_W'(r_p);
                        r_mul_go <= 1'b1;
                        r_state  <= S_PP;
                    end
                end
                S_PP: begin
                    if (mul_done) begin
                        r_den    <= DIVS_W'(r_m2) + DIVS_W'(mul_prod[31:0]);
                        r_mul_a  <= MUL_A_W'(r_m2);
                        r_mul_b  <= r_t;
                        r_mul_go <= 1'b1;
                        r_state  <= S_TM;
                    end
                end
                S_TM: begin
                    if (mul_done) begin
                        r_div_n  <= DIVD_W'(mul_prod);
                        r_div_d  <= r_den;
                        r_div_go <= 1'b1;
                        r_state  <= S_TM_DIV;
                    end
                end
                S_TM_DIV: begin
                    if (div_done) begin
                        r_mul_a  <= MUL_A_W'(r_dpp);
                        r_mul_b  <= T_W'(div_quot);
                        r_mul_go <= 1'b1;
                        r_state  <= S_DR;
                    end
                end
                // momentum spread term: clips the result when it alone is too large, else it is squared
                S_DR: begin
                    if (mul_done) begin
                        if (st_full > (PROD_W-20)'(MAX_SIGMA)) begin
                            r_root  <= MAX_SIGMA;
                            r_sat   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_mul_a  <= MUL_A_W'(st_full[SIG_W-1:0]);
                            r_mul_b  <= MUL_B_W'(st_full[SIG_W-1:0]);
                            r_mul_go <= 1'b1;
                            r_state  <= S_SQ_ST;
                        end
                    end
                end
                S_SQ_ST: begin
                    if (mul_done) begin
                        r_sum    <= SUM_W'(mul_prod);
                        r_div_n  <= DIVD_W'(r_d);
                        r_div_d  <= DIVS_W'(r_p);
                        r_div_go <= 1'b1;
                        r_state  <= S_MS_DIV;
                    end
                end
                S_MS_DIV: begin
                    if (div_done) begin
                        r_mul_a  <= MUL_A_W'(div_quot[SIG_W-1:0]);
                        r_mul_b  <= MUL_B_W'(div_quot[SIG_W-1:0]);
                        r_mul_go <= 1'b1;
                        r_state  <= S_SQ_MS;
                    end
                end
                S_SQ_MS: begin
                    if (mul_done) begin
                        r_sum    <= r_sum + SUM_W'(mul_prod);
                        r_mul_a  <= MUL_A_W'(r_s);
                        r_mul_b  <= MUL_B_W'(r_s);
                        r_mul_go <= 1'b1;
                        r_state  <= S_SQ_S;
                    end
                end
                S_SQ_S: begin
                    if (mul_done) begin
                        r_sum    <= r_sum + SUM_W'(mul_prod);
                        r_mul_a  <= MUL_A_W'(r_table[r_bin]);
                        r_mul_b  <= MUL_B_W'(r_table[r_bin]);
                        r_mul_go <= 1'b1;
                        r_state  <= S_SQ_T0;
                    end
                end
                S_SQ_T0: begin
                    if (mul_done) begin
                        r_sum     <= r_sum + SUM_W'(mul_prod);
                        r_sqrt_go <= 1'b1;
                        r_state   <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        if (sqrt_root > ROOT_W'(MAX_SIGMA)) begin
                            r_root <= MAX_SIGMA;
                            r_sat  <= 1'b1;
                        end else begin
                            r_root <= sqrt_root[SIG_W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                // hand over once the output register is free
                S_OUT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_o_sig <= r_root;
                        r_o_bin <= r_bin;
                        r_o_sat <= r_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // clipped result always reads full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[SIG_W-1:0] == MAX_SIGMA)
        else $error("saturated word without full-scale sigma");

    // shared units never finish together
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && div_done) && !(mul_done && sqrt_done) && !(div_done && sqrt_done))
        else $error("two arithmetic units finished in one cycle");

    // bin stays below the bin count
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:20] <= BIN_W'(NBINS - 1))
        else $error("momentum bin out of range");

    // intrinsic sigma write lands
    a_cfg_s: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index == REG_S |=> r_s == $past(i_cfg_data[15:0]))
        else $error("intrinsic sigma write lost");

endmodule

// File: rtl/tesig_mul.sv
`timescale 1ns / 1ps

module tesig_mul
    import tesig_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [PROD_W-1:0]  o_prod
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [PROD_W-1:0]  r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [PROD_W-1:0]  r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    // shift and add, one multiplier bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= PROD_W'(i_a);
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= {r_a[PROD_W-2:0], 1'b0};
                r_b   <= {1'b0, r_b[MUL_B_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/tesig_div.sv
`timescale 1ns / 1ps

module tesig_div
    import tesig_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIVD_W);
    localparam int REM_W = DIVS_W + 1;

    logic [DIVD_W-1:0] r_q;
    logic [REM_W-1:0]  r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  rem_sh;
    logic              ge;

    // restoring step: bring down one dividend bit, try the subtract
    assign rem_sh = {r_rem[REM_W-2:0], r_q[DIVD_W-1]};
    assign ge     = (rem_sh >= REM_W'(r_dvs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? (rem_sh - REM_W'(r_dvs)) : rem_sh;
                r_q   <= {r_q[DIVD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: rtl/tesig_sqrt.sv
`timescale 1ns / 1ps

module tesig_sqrt
    import tesig_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    logic [RAD_W-1:0]  r_v;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // one root bit a cycle from the next radicand bit pair
    assign rem_sh = {r_rem[REM_W-3:0], r_v[RAD_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], ge};
                r_v    <= {r_v[RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: verif/tof_expected_time_sigma_checker.sv
`timescale 1ns / 1ps

module tof_expected_time_sigma_checker
    import tesig_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic        i_out_user,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic       sat;
        logic [3:0] bin;
        logic [19:0] sigma;
    } t_sigma_word;

    logic [19:0] coef_a, coef_b, coef_c, coef_d;
    logic [15:0] intr_s;
    logic [15:0] t0_table [TBL_DEPTH];
    t_sigma_word sigma_queue [$];

    // momentum bin from the boundary list
    function automatic logic [3:0] bin_of(input int unsigned p);
        int unsigned bounds [11] = '{300, 500, 600, 700, 800, 900, 1000, 1200,
                                     1500, 2000, 3000};
        int unsigned n;
        n = 0;
        while (n < NBINS && n < 11 && p > bounds[n]) n++;
        if (n > 0) n--;
        return n[3:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic t_sigma_word predict_sigma(input logic [71:0] d);
        longint unsigned p, t, m, dpp, m2, p2, r, st, ms, t0, sum, root;
        t_sigma_word w;
        p = d[15:0];
        t = d[39:16];
        m = d[55:40];
        if (p == 0) p = 1;
        if (m == 0) m = 1;
        dpp = coef_a + (coef_b * p) / 1000 + (coef_c * m) / p;
        m2 = m * m;
        p2 = p * p;
        r = (t * m2) / (m2 + p2);
        st = (dpp * r) >> 20;
        ms = coef_d / p;
        w.bin = bin_of(p);
        t0 = t0_table[w.bin];
        w.sat = 1'b0;
        if (st > 1048575) begin
            root = 1048575;
            w.sat = 1'b1;
        end else begin
            sum = st * st + ms * ms + intr_s * intr_s + t0 * t0;
            root = int_sqrt(sum);
            if (root > 1048575) begin
                root = 1048575;
                w.sat = 1'b1;
            end
        end
        w.sigma = root[19:0];
        return w;
    endfunction

    assign o_pending = sigma_queue.size();

    // watch all three channels
    always @(posedge i_clk) begin
        t_sigma_word exp_w;
        if (!i_rst_n) begin
            coef_a <= 20'd8389;
            coef_b <= 20'd8389;
            coef_c <= 20'd2097;
            coef_d <= 20'd40000;
            intr_s <= '0;
            for (int i = 0; i < TBL_DEPTH; i++) t0_table[i] <= '0;
            sigma_queue.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_A: coef_a <= i_cfg_data;
                    REG_B: coef_b <= i_cfg_data;
                    REG_C: coef_c <= i_cfg_data;
                    REG_D: coef_d <= i_cfg_data;
                    REG_S: intr_s <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user == OP_LOAD) t0_table[i_in_data[3:0]] <= i_in_data[71:56];
                else sigma_queue.push_back(predict_sigma(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (sigma_queue.size() == 0) begin
                    $display("%0t unexpected word: actual %h/%b", $time,
                             i_out_data, i_out_user);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = sigma_queue.pop_front();
                    if (exp_w.sigma !== i_out_data[19:0] || exp_w.bin !== i_out_data[23:20]
                        || exp_w.sat !== i_out_user) begin
                        $display({"%0t mismatch: expected sigma %0d bin %0d sat %b,",
                                  " actual sigma %0d bin %0d sat %b"},
                                 $time, exp_w.sigma, exp_w.bin, exp_w.sat,
                                 i_out_data[19:0], i_out_data[23:20], i_out_user);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: verif/tof_expected_time_sigma_core_tb.sv
`timescale 1ns / 1ps

module tof_expected_time_sigma_core_tb
    import tesig_pkg::*;
;

    localparam longint CYCLE_LIMIT = 6000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    int  errors, pending;
    int  send_idle_pct, recv_idle_pct;
    int  hold_off;
    longint cycles;

    tof_expected_time_sigma_core dut (.*);

    tof_expected_time_sigma_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver with random stalls and a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up into the next write; set_coefs drops it at the end
    task automatic cfg_write(input logic [2:0] idx, input logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // valid stays up into the next word; idling or draining drops it
    task automatic send_word(input logic op, input logic [15:0] p, input logic [23:0] t,
                             input logic [15:0] m, input logic [15:0] lv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {lv, m, t, p};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic set_coefs(input logic [19:0] a, b, c, d, input logic [15:0] s);
        drain_results();
        cfg_write(REG_A, a);
        cfg_write(REG_B, b);
        cfg_write(REG_C, c);
        cfg_write(REG_D, d);
        cfg_write(REG_S, {4'd0, s});
        cfg_write(3'd7, 20'hFFFFF);
        i_cfg_valid <= 1'b0;
    endtask

    // small momenta or ones near the bin edges half the time, anything the other half
    function automatic logic [15:0] rand_momentum();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3200));
            1: return 16'($urandom_range(310, 290) + 100 * $urandom_range(27));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                send_word(OP_LOAD, 16'($urandom()), 24'($urandom()), 16'($urandom()),
                          16'($urandom()));
            else
                send_word(OP_COMPUTE, rand_momentum(), 24'($urandom()),
                          ($urandom_range(1)) ? 16'($urandom_range(2000)) : 16'($urandom()),
                          16'($urandom()));
        end
    endtask

    initial begin
        int bounds [12] = '{300, 301, 500, 501, 900, 1000, 1001, 2000, 2001, 3000, 3001, 65535};
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 28;
        recv_idle_pct = 52;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: table loads incl. entries past the bin count, then bin edges
        for (int k = 0; k < 16; k += 3)
            send_word(OP_LOAD, 16'(16'hFFF0 | k), '1, '1, 16'(100 * k + 7));
        send_word(OP_LOAD, 16'd15, '0, '0, 16'hFFFF);
        for (int k = 0; k < 12; k++)
            send_word(OP_COMPUTE, 16'(bounds[k]), 24'd20000, 16'd140, '0);
        send_word(OP_COMPUTE, 16'd0, 24'd20000, 16'd0, '0);
        send_word(OP_COMPUTE, 16'd1, 24'hFFFFFF, 16'hFFFF, '1);
        send_word(OP_COMPUTE, 16'hFFFF, 24'hFFFFFF, 16'h1, '1);
        send_word(OP_COMPUTE, 16'd1, 24'd0, 16'd1, '1);

        // extreme coefficients: large spread clips, then root clips
        set_coefs('1, '1, '1, '1, '1);
        send_word(OP_COMPUTE, 16'd1, 24'hFFFFFF, 16'hFFFF, '0);
        send_word(OP_COMPUTE, 16'd1, 24'd0, 16'd1, '0);
        send_word(OP_COMPUTE, 16'd800, 24'd30000, 16'd938, '0);
        random_items(300);

        set_coefs('0, '0, '0, '0, '0);
        random_items(150);

        // long receiver hold-off so the input backs up
        hold_off = 3000;
        random_items(20);

        set_coefs(20'd8389, 20'd8389, 20'd2097, 20'd40000, 16'd80);
        send_idle_pct = 52;
        recv_idle_pct = 28;
        random_items(500);

        set_coefs(20'($urandom()), 20'($urandom()), 20'($urandom()), 20'($urandom()),
                  16'($urandom()));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(400);

        set_coefs(20'($urandom_range(50000)), 20'($urandom_range(50000)),
                  20'($urandom_range(50000)), 20'($urandom()), 16'($urandom_range(300)));
        random_items(450);

        drain_results();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
